[hw/rtl/i2cept_pkg.sv]
// Package for the I2C EEPROM page transfer sequencer.
// Holds the status codes, address constants and the result record.
// It has no dependencies.
package i2cept_pkg;

  // Controller status codes that the sequencer decodes.
  localparam logic [7:0] ST_BUS_ERROR    = 8'h00;
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_RESTART      = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK    = 8'h18;
  localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
  localparam logic [7:0] ST_SLA_R_ACK    = 8'h40;
  localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

  // Device addresses for the lower and upper halves of the array.
  localparam logic [7:0] DEV_ADDR_LO = 8'hA0;
  localparam logic [7:0] DEV_ADDR_HI = 8'hA2;

  // Input beat kinds.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_EVENT = 1'b1;

  // Acknowledge actions.
  localparam logic [1:0] ACK_KEEP  = 2'd0;
  localparam logic [1:0] ACK_SET   = 2'd1;
  localparam logic [1:0] ACK_CLEAR = 2'd2;

  // Register indexes of the configuration port.
  localparam logic REG_PAGE_NUMBER = 1'b0;
  localparam logic REG_DIRECTION   = 1'b1;

  typedef struct packed {
    logic [7:0] drive_byte;
    logic       drive_valid;
    logic       set_start;
    logic       clear_start;
    logic       set_stop;
    logic [1:0] ack_action;
    logic       clear_flag;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       write_byte_used;
    logic       done_res;
  } result_t;

endpackage

[hw/rtl/i2cept_cfg.sv]
// Configuration registers of the I2C EEPROM page transfer sequencer.
// APB-style write and read of page number and direction; uses i2cept_pkg.
module i2cept_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [8:0]  page_number_o,
  output logic        direction_o
);
  import i2cept_pkg::*;

  logic [8:0] page_number_q, page_number_d;
  logic       direction_q, direction_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    page_number_d = page_number_q;
    direction_d   = direction_q;
    if (wr_en) begin
      case (paddr[2])
        REG_PAGE_NUMBER: page_number_d = pwdata[8:0];
        REG_DIRECTION:   direction_d   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_number_q <= '0;
      direction_q   <= 1'b0;
    end else begin
      page_number_q <= page_number_d;
      direction_q   <= direction_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PAGE_NUMBER: prdata = {23'd0, page_number_q};
      REG_DIRECTION:   prdata = {31'd0, direction_q};
      default:         prdata = '0;
    endcase
  end

  assign page_number_o = page_number_q;
  assign direction_o   = direction_q;

endmodule

[hw/rtl/i2cept_decode.sv]
// Event decoder of the I2C EEPROM page transfer sequencer.
// Turns one beat plus the current state into controller actions and next state.
// Uses i2cept_pkg for status codes and the result record.
module i2cept_decode #(
  parameter int PAGE_BYTES = 32,
  parameter int CNT_W      = 6
) (
  input  logic                      mode_i,
  input  logic [7:0]                status_code_i,
  input  logic [7:0]                bus_byte_i,
  input  logic [7:0]                write_byte_i,
  input  logic [8:0]                page_number_i,
  input  logic                      direction_i,
  input  logic                      addr_low_sent_i,
  input  logic [CNT_W-1:0]          byte_count_i,
  input  logic                      finished_i,
  output logic                      addr_low_sent_o,
  output logic [CNT_W-1:0]          byte_count_o,
  output logic                      finished_o,
  output i2cept_pkg::result_t       result_o
);
  import i2cept_pkg::*;

  localparam logic [CNT_W-1:0] CNT_PAGE = CNT_W'(PAGE_BYTES);
  localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(PAGE_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAGE_BYTES - 1);

  logic [7:0]       dev_addr;
  logic [15:0]      byte_addr;
  logic [CNT_W-1:0] count_inc;

  assign dev_addr  = (page_number_i > 9'd255) ? DEV_ADDR_HI : DEV_ADDR_LO;
  assign byte_addr = 16'(32'(page_number_i) * PAGE_BYTES);
  // Counter saturates one past the page size.
  assign count_inc = (byte_count_i < CNT_SAT) ? byte_count_i + 1'b1 : byte_count_i;

  always_comb begin
    result_o        = '0;
    addr_low_sent_o = addr_low_sent_i;
    byte_count_o    = byte_count_i;
    finished_o      = finished_i;

    if (mode_i == MODE_START) begin
      finished_o         = 1'b0;
      result_o.set_start = 1'b1;
    end else if (!finished_i) begin
      case (status_code_i)
        ST_START: begin
          result_o.drive_byte  = dev_addr;
          result_o.drive_valid = 1'b1;
          result_o.clear_start = 1'b1;
          result_o.clear_flag  = 1'b1;
        end
        ST_SLA_W_ACK: begin
          result_o.drive_byte  = byte_addr[15:8];
          result_o.drive_valid = 1'b1;
          result_o.clear_flag  = 1'b1;
          addr_low_sent_o      = 1'b0;
        end
        ST_DATA_TX_ACK: begin
          result_o.clear_flag = 1'b1;
          if (!addr_low_sent_i) begin
            result_o.drive_byte  = byte_addr[7:0];
            result_o.drive_valid = 1'b1;
            addr_low_sent_o      = 1'b1;
            byte_count_o         = '0;
          end else if (!direction_i) begin
            if (byte_count_i < CNT_PAGE) begin
              result_o.drive_byte      = write_byte_i;
              result_o.drive_valid     = 1'b1;
              result_o.write_byte_used = 1'b1;
            end else begin
              finished_o        = 1'b1;
              result_o.set_stop = 1'b1;
              result_o.done_res = 1'b1;
            end
            byte_count_o = count_inc;
          end else begin
            result_o.set_start = 1'b1;
          end
        end
        ST_RESTART: begin
          result_o.drive_byte  = dev_addr + 8'd1;
          result_o.drive_valid = 1'b1;
          result_o.clear_start = 1'b1;
          result_o.clear_flag  = 1'b1;
        end
        ST_SLA_R_ACK: begin
          byte_count_o        = '0;
          result_o.ack_action = ACK_SET;
          result_o.clear_flag = 1'b1;
        end
        ST_DATA_RX_ACK: begin
          result_o.rx_byte  = bus_byte_i;
          result_o.rx_valid = 1'b1;
          byte_count_o      = count_inc;
          // The byte after this one is the last of the page: answer it with NACK.
          if (count_inc == CNT_LAST) begin
            result_o.ack_action = ACK_CLEAR;
          end
          result_o.clear_flag = 1'b1;
        end
        ST_DATA_RX_NACK: begin
          result_o.rx_byte    = bus_byte_i;
          result_o.rx_valid   = 1'b1;
          finished_o          = 1'b1;
          result_o.done_res   = 1'b1;
          result_o.set_stop   = 1'b1;
          result_o.clear_flag = 1'b1;
        end
        ST_BUS_ERROR: begin
          result_o.set_stop   = 1'b1;
          result_o.clear_flag = 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/i2c_eeprom_page_transfer_sequencer.sv]
// I2C EEPROM page transfer sequencer: each input beat is held in the input register, then
// its decode is held in the result register; throughput is one beat per cycle while the
// output side does not stall. The decode between the two registers is a single pass.
// Reset clears the sequencing state (address flag, byte counter, finished flag), both
// configuration registers and both valid flags; no clearing pass is needed.
// Depends on i2cept_pkg, i2cept_cfg and i2cept_decode.
module i2c_eeprom_page_transfer_sequencer #(
  parameter int PAGE_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel: one bus event or start request per beat.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  status_code_i,
  input  logic [7:0]  bus_byte_i,
  input  logic [7:0]  write_byte_i,
  // Output channel: one set of controller actions per beat.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  drive_byte_o,
  output logic        drive_valid_o,
  output logic        set_start_o,
  output logic        clear_start_o,
  output logic        set_stop_o,
  output logic [1:0]  ack_action_o,
  output logic        clear_flag_o,
  output logic [7:0]  rx_byte_o,
  output logic        rx_valid_o,
  output logic        write_byte_used_o,
  output logic        done_res_o
);
  import i2cept_pkg::*;

  // The byte counter saturates one past the page size.
  localparam int CNT_W = $clog2(PAGE_BYTES + 2);

  logic [8:0] page_number;
  logic       direction;

  i2cept_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .page_number_o (page_number),
    .direction_o   (direction)
  );

  // Input register. It holds one beat until the result register can take its decode.
  logic       in_valid_q;
  logic       mode_q;
  logic [7:0] status_code_q;
  logic [7:0] bus_byte_q;
  logic [7:0] write_byte_q;

  // Result register.
  logic    out_valid_q;
  result_t result_q;
  result_t result_d;

  // Sequencing state. It advances only when a beat moves from the input register
  // into the result register, so beats are decoded strictly in order.
  logic             addr_low_sent_q, addr_low_sent_d;
  logic [CNT_W-1:0] byte_count_q, byte_count_d;
  logic             finished_q, finished_d;

  logic out_free;
  logic advance;
  logic in_take;

  // The result register is free when empty or when its beat leaves this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  // A new beat enters whenever the input register is empty or drains this cycle.
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  i2cept_decode #(
    .PAGE_BYTES (PAGE_BYTES),
    .CNT_W      (CNT_W)
  ) u_decode (
    .mode_i          (mode_q),
    .status_code_i   (status_code_q),
    .bus_byte_i      (bus_byte_q),
    .write_byte_i    (write_byte_q),
    .page_number_i   (page_number),
    .direction_i     (direction),
    .addr_low_sent_i (addr_low_sent_q),
    .byte_count_i    (byte_count_q),
    .finished_i      (finished_q),
    .addr_low_sent_o (addr_low_sent_d),
    .byte_count_o    (byte_count_d),
    .finished_o      (finished_d),
    .result_o        (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      addr_low_sent_q <= 1'b0;
      byte_count_q    <= '0;
      finished_q      <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q     <= 1'b1;
        addr_low_sent_q <= addr_low_sent_d;
        byte_count_q    <= byte_count_d;
        finished_q      <= finished_d;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q        <= mode_i;
      status_code_q <= status_code_i;
      bus_byte_q    <= bus_byte_i;
      write_byte_q  <= write_byte_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_byte_o      = result_q.drive_byte;
  assign drive_valid_o     = result_q.drive_valid;
  assign set_start_o       = result_q.set_start;
  assign clear_start_o     = result_q.clear_start;
  assign set_stop_o        = result_q.set_stop;
  assign ack_action_o      = result_q.ack_action;
  assign clear_flag_o      = result_q.clear_flag;
  assign rx_byte_o         = result_q.rx_byte;
  assign rx_valid_o        = result_q.rx_valid;
  assign write_byte_used_o = result_q.write_byte_used;
  assign done_res_o        = result_q.done_res;

endmodule
